FILE: hdl/decaying_wave_height_grid_assert.svh
// Assertion macros for the decaying wave height grid checker.
// Plain text macros; no other file or package needed.
`ifndef DECAYING_WAVE_HEIGHT_GRID_ASSERT_SVH
`define DECAYING_WAVE_HEIGHT_GRID_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define DWH_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dwh check failed: same-cycle rule");

// Check a consequence in the cycle after its cause.
`define DWH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dwh check failed: next-cycle rule");

`endif

FILE: hdl/dwh_pkg.sv
// Shared types, constants and coefficient tables for the decaying wave grid.
// No dependencies; every other file but the assertion header imports this package.
`default_nettype none

package dwh_pkg;

  // Field widths
  localparam int MAX_POINTS = 256;
  localparam int PTS_W      = 9;
  localparam int IDX_W      = 8;
  localparam int POS_W      = 20;
  localparam int HGT_W      = 19;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Fixed-point constants
  localparam logic [POS_W-1:0] FOURPI_Q16 = 20'd823550;
  localparam logic [30:0]      HALFPI_Q30 = 31'd1686629713;
  localparam logic [37:0]      LN2_Q32    = 38'd2977044472;
  localparam logic [30:0]      ONE_Q30    = 31'h4000_0000;
  localparam logic [19:0]      HEIGHT_MAX = 20'd131072;

  // Divider cells: shared remainder and shift-word widths
  localparam int REM_W      = 16;
  localparam int DIV_W      = 52;
  localparam int POS_DIVD_W = 28;

  // Series evaluation
  localparam int LN2_STEPS = 7;
  localparam int SIN_TERMS = 6;
  localparam int EXP_TERMS = 9;
  localparam int HC_STAGES = 3;

  // Pipeline stage numbers, counted in registers after acceptance
  localparam int STG_IN   = 1;
  localparam int STG_TP   = STG_IN + 1;
  localparam int STG_POS  = STG_IN + POS_DIVD_W;
  localparam int STG_SPC  = STG_POS + DIV_W;
  localparam int STG_PH   = STG_SPC + 1;
  localparam int STG_A    = STG_PH + 1;
  localparam int STG_A2   = STG_A + 1;
  localparam int STG_SH   = STG_A2 + SIN_TERMS * HC_STAGES;
  localparam int STG_SIN  = STG_SH + 1;
  localparam int STG_SUM  = STG_SIN + 1;
  localparam int STG_P    = STG_SUM + 1;
  localparam int STG_PROD = STG_P + 1;
  localparam int STG_OUT  = STG_PROD + 1;
  localparam int STG_V    = STG_POS + 1;
  localparam int STG_LN   = STG_V + LN2_STEPS;
  localparam int STG_EH   = STG_LN + EXP_TERMS * HC_STAGES;
  localparam int STG_E    = STG_EH + 1;

  // Delay line lengths for side data
  localparam int ACT_DLY = STG_SIN - STG_IN;
  localparam int TP_DLY  = STG_SPC - STG_TP;
  localparam int POS_DLY = STG_PROD - STG_POS;
  localparam int E_DLY   = STG_P - STG_E;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE = 3'd0,
    REG_LENGTH    = 3'd1,
    REG_FREQUENCY = 3'd2,
    REG_PITCH     = 3'd3,
    REG_DECAY     = 3'd4,
    REG_POINTS_X  = 3'd5,
    REG_POINTS_Y  = 3'd6
  } cfg_reg_e;

  // Restoring divider cell state: partial remainder and dividend/quotient word
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] word;
  } div_t;

  // Horner cell state: multiplier operand, running term, side data
  typedef struct packed {
    logic [31:0] op;
    logic [30:0] t;
    logic [31:0] aux;
  } hrn_t;

  // Sine series divisors k*(k+1) for k = 12, 10, .., 2 and floor(2^32/c)
  localparam logic [7:0] SIN_COEF [SIN_TERMS] = '{
    8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
  };
  localparam logic [31:0] SIN_RECIP [SIN_TERMS] = '{
    32'd27531841, 32'd39045157, 32'd59652323,
    32'd102261126, 32'd214748364, 32'd715827882
  };

  // Exponential series divisors k = 9 .. 1; divide by one uses all ones
  localparam logic [7:0] EXP_COEF [EXP_TERMS] = '{
    8'd9, 8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1
  };
  localparam logic [31:0] EXP_RECIP [EXP_TERMS] = '{
    32'd477218588, 32'd536870912, 32'd613566756,
    32'd715827882, 32'd858993459, 32'd1073741824,
    32'd1431655765, 32'd2147483648, 32'd4294967295
  };

endpackage

`default_nettype wire

FILE: hdl/dwh_if.sv
// Valid/ready channel interfaces: grid point in, result out, register writes.
// Depends on dwh_pkg for field widths.
`default_nettype none

interface dwh_item_if import dwh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  col_index;
  logic [IDX_W-1:0]  row_index;
  logic [TIME_W-1:0] time_value;
  logic              action;

  modport source (output valid, col_index, row_index, time_value, action, input ready);
  modport sink   (input valid, col_index, row_index, time_value, action, output ready);
endinterface

interface dwh_res_if import dwh_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [POS_W-1:0]        x_pos;
  logic [POS_W-1:0]        y_pos;
  logic signed [HGT_W-1:0] height;

  modport source (output valid, x_pos, y_pos, height, input ready);
  modport sink   (input valid, x_pos, y_pos, height, output ready);
endinterface

interface dwh_cfg_if import dwh_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/decaying_wave_height_grid.sv
// Top level of the decaying wave height grid: register file and cell pipeline.
// Depends on dwh_pkg, dwh_if, dwh_div_cell and dwh_horner_cell.
//
// Use: item_i takes one grid point (column, row, time, wave type) per
// transaction; res_o returns its x/y position and damped wave height, one
// result per point, in order. cfg_i writes the seven registers by index
// (0 amplitude .. 6 rows); it is always ready and must only be used while no
// point is in flight. Unknown indexes are dropped.
// A point passes the input register, the 28-cell position divider, the 52-cell
// phase divider and six 3-stage sine series cells in a row on its way to res_o.
// Throughput: one point per cycle while res_o is not stalled.
// Reset clears the registers to their defaults and empties the pipeline.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and item_i.ready drops until the result is taken.
`default_nettype none

module decaying_wave_height_grid import dwh_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  dwh_item_if.sink   item_i,
  dwh_cfg_if.sink    cfg_i,
  dwh_res_if.source  res_o
);

  // ---------------- configuration registers ----------------
  logic [16:0]      amp_q;
  logic [15:0]      len_q;
  logic [15:0]      freq_q;
  logic [18:0]      pitch_q;
  logic [17:0]      decay_q;
  logic [PTS_W-1:0] nx_q, ny_q;

  assign cfg_i.ready = 1'b1;

  // Take register writes by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q   <= 17'd32768;
      len_q   <= 16'd6554;
      freq_q  <= 16'd20000;
      pitch_q <= 19'd65536;
      decay_q <= 18'd13107;
      nx_q    <= 9'd150;
      ny_q    <= 9'd150;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_AMPLITUDE: amp_q   <= cfg_i.data[16:0];
        REG_LENGTH:    len_q   <= cfg_i.data[15:0];
        REG_FREQUENCY: freq_q  <= cfg_i.data[15:0];
        REG_PITCH:     pitch_q <= cfg_i.data[18:0];
        REG_DECAY:     decay_q <= cfg_i.data[17:0];
        REG_POINTS_X:  nx_q    <= cfg_i.data[PTS_W-1:0];
        REG_POINTS_Y:  ny_q    <= cfg_i.data[PTS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp grid sizes and wavelength
  logic [PTS_W-1:0] nx, ny;
  logic [15:0]      len_eff;

  always_comb begin
    nx = (nx_q < PTS_W'(2)) ? PTS_W'(2) :
         (nx_q > PTS_W'(MAX_POINTS)) ? PTS_W'(MAX_POINTS) : nx_q;
    ny = (ny_q < PTS_W'(2)) ? PTS_W'(2) :
         (ny_q > PTS_W'(MAX_POINTS)) ? PTS_W'(MAX_POINTS) : ny_q;
    len_eff = (len_q == 16'd0) ? 16'd1 : len_q;
  end

  // ---------------- pipeline control ----------------
  logic [STG_OUT:1] vld_q;
  logic             adv;

  assign adv          = !vld_q[STG_OUT] || res_o.ready;
  assign item_i.ready = adv;

  // Shift valid bits along with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[STG_OUT-1:1], item_i.valid};
    end
  end

  // ---------------- input stage ----------------
  logic [IDX_W-1:0]      col_cl, row_cl;
  logic [POS_DIVD_W-1:0] dvx, dvy;
  logic [31:0]           fp;
  div_t                  posx0_q, posy0_q;
  logic [TIME_W-1:0]     t_q;
  logic [31:0]           fp_q;
  logic                  act_q;

  // Clamp indexes and form the rounded position dividends
  always_comb begin
    col_cl = ({1'b0, item_i.col_index} >= nx) ? IDX_W'(nx - PTS_W'(1)) : item_i.col_index;
    row_cl = ({1'b0, item_i.row_index} >= ny) ? IDX_W'(ny - PTS_W'(1)) : item_i.row_index;
    dvx    = POS_DIVD_W'(col_cl) * POS_DIVD_W'(FOURPI_Q16) + POS_DIVD_W'(nx >> 1);
    dvy    = POS_DIVD_W'(row_cl) * POS_DIVD_W'(FOURPI_Q16) + POS_DIVD_W'(ny >> 1);
    fp     = 32'(freq_q) * 32'(pitch_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      posx0_q <= '{rem: '0, word: {dvx, {(DIV_W-POS_DIVD_W){1'b0}}}};
      posy0_q <= '{rem: '0, word: {dvy, {(DIV_W-POS_DIVD_W){1'b0}}}};
      t_q     <= item_i.time_value;
      fp_q    <= fp;
      act_q   <= item_i.action;
    end
  end

  // Temporal phase in turns, low 32 bits
  logic [31:0] tp_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tp_q <= fp_q * t_q;
    end
  end

  // ---------------- position dividers ----------------
  div_t posx [POS_DIVD_W+1];
  div_t posy [POS_DIVD_W+1];

  assign posx[0] = posx0_q;
  assign posy[0] = posy0_q;

  for (genvar i = 0; i < POS_DIVD_W; i++) begin : g_pos
    dwh_div_cell u_xcell (
      .clk_i     (clk_i),
      .en_i      (adv),
      .divisor_i (REM_W'(nx)),
      .in_i      (posx[i]),
      .out_o     (posx[i+1])
    );
    dwh_div_cell u_ycell (
      .clk_i     (clk_i),
      .en_i      (adv),
      .divisor_i (REM_W'(ny)),
      .in_i      (posy[i]),
      .out_o     (posy[i+1])
    );
  end

  logic [POS_W-1:0] xp, yp;

  assign xp = posx[POS_DIVD_W].word[POS_W-1:0];
  assign yp = posy[POS_DIVD_W].word[POS_W-1:0];

  // ---------------- spatial phase divider ----------------
  div_t spc [DIV_W+1];

  assign spc[0] = '{rem: '0, word: {xp, 32'b0}};

  for (genvar i = 0; i < DIV_W; i++) begin : g_spc
    dwh_div_cell u_cell (
      .clk_i     (clk_i),
      .en_i      (adv),
      .divisor_i (len_eff),
      .in_i      (spc[i]),
      .out_o     (spc[i+1])
    );
  end

  // ---------------- side data delay lines ----------------
  logic              act_line_q [ACT_DLY];
  logic [31:0]       tp_line_q  [TP_DLY];
  logic [POS_W-1:0]  xp_line_q  [POS_DLY];
  logic [POS_W-1:0]  yp_line_q  [POS_DLY];
  logic [30:0]       e_line_q   [E_DLY];
  logic [30:0]       e_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      act_line_q[0] <= act_q;
      for (int i = 1; i < ACT_DLY; i++) act_line_q[i] <= act_line_q[i-1];
      tp_line_q[0] <= tp_q;
      for (int i = 1; i < TP_DLY; i++) tp_line_q[i] <= tp_line_q[i-1];
      xp_line_q[0] <= xp;
      yp_line_q[0] <= yp;
      for (int i = 1; i < POS_DLY; i++) begin
        xp_line_q[i] <= xp_line_q[i-1];
        yp_line_q[i] <= yp_line_q[i-1];
      end
      e_line_q[0] <= e_q;
      for (int i = 1; i < E_DLY; i++) e_line_q[i] <= e_line_q[i-1];
    end
  end

  // ---------------- forward and backward phases ----------------
  logic [31:0] ph_q [2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ph_q[0] <= spc[DIV_W].word[31:0] - tp_line_q[TP_DLY-1];
      ph_q[1] <= spc[DIV_W].word[31:0] + tp_line_q[TP_DLY-1];
    end
  end

  // ---------------- sine lanes ----------------
  logic signed [31:0] sin_q [2];

  for (genvar w = 0; w < 2; w++) begin : g_sine
    logic [30:0] r_fold;
    logic [61:0] a_prod;
    logic [30:0] a_q;
    logic        neg_q;
    logic [61:0] a2_prod;
    logic [31:0] a2_q;
    logic [30:0] a3_q;
    logic        neg3_q;
    hrn_t        hrn [SIN_TERMS+1];
    logic [61:0] s_prod;
    logic [31:0] s_raw;
    logic [30:0] s_mag;

    // Fold the quarter turn and scale it to radians
    always_comb begin
      r_fold  = ph_q[w][30] ? (ONE_Q30 - {1'b0, ph_q[w][29:0]}) : {1'b0, ph_q[w][29:0]};
      a_prod  = 62'(r_fold) * 62'(HALFPI_Q30);
      a2_prod = 62'(a_q) * 62'(a_q);
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        a_q    <= a_prod[60:30];
        neg_q  <= ph_q[w][31];
        a2_q   <= a2_prod[61:30];
        a3_q   <= a_q;
        neg3_q <= neg_q;
      end
    end

    assign hrn[0] = '{op: a2_q, t: ONE_Q30, aux: {neg3_q, a3_q}};

    for (genvar k = 0; k < SIN_TERMS; k++) begin : g_term
      dwh_horner_cell u_cell (
        .clk_i   (clk_i),
        .en_i    (adv),
        .coef_i  (SIN_COEF[k]),
        .recip_i (SIN_RECIP[k]),
        .in_i    (hrn[k]),
        .out_o   (hrn[k+1])
      );
    end

    // Final multiply by the angle, clip at one, apply the sign
    always_comb begin
      s_prod = 62'(hrn[SIN_TERMS].aux[30:0]) * 62'(hrn[SIN_TERMS].t);
      s_raw  = s_prod[61:30];
      s_mag  = (s_raw > 32'(ONE_Q30)) ? ONE_Q30 : s_raw[30:0];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sin_q[w] <= hrn[SIN_TERMS].aux[31] ? -$signed(32'(s_mag)) : $signed(32'(s_mag));
      end
    end
  end

  // ---------------- decay factor ----------------
  logic [37:0] ln_rem_q [LN2_STEPS+1];
  logic [6:0]  ln_n_q   [LN2_STEPS+1];

  // Split the exponent into whole powers of two and a remainder
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ln_rem_q[0] <= 38'(decay_q) * 38'(yp);
      ln_n_q[0]   <= '0;
      for (int j = 0; j < LN2_STEPS; j++) begin
        if (ln_rem_q[j] >= (LN2_Q32 << (LN2_STEPS - 1 - j))) begin
          ln_rem_q[j+1] <= ln_rem_q[j] - (LN2_Q32 << (LN2_STEPS - 1 - j));
          ln_n_q[j+1]   <= ln_n_q[j] | (7'd1 << (LN2_STEPS - 1 - j));
        end else begin
          ln_rem_q[j+1] <= ln_rem_q[j];
          ln_n_q[j+1]   <= ln_n_q[j];
        end
      end
    end
  end

  hrn_t exh [EXP_TERMS+1];

  assign exh[0] = '{op: {2'b0, ln_rem_q[LN2_STEPS][31:2]}, t: ONE_Q30,
                    aux: {25'b0, ln_n_q[LN2_STEPS]}};

  for (genvar k = 0; k < EXP_TERMS; k++) begin : g_exp
    dwh_horner_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .coef_i  (EXP_COEF[k]),
      .recip_i (EXP_RECIP[k]),
      .in_i    (exh[k]),
      .out_o   (exh[k+1])
    );
  end

  // Scale by the power of two, flush to zero when it runs out
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_q <= (exh[EXP_TERMS].aux[6:0] >= 7'd31) ? '0 :
             (exh[EXP_TERMS].t >> exh[EXP_TERMS].aux[6:0]);
    end
  end

  // ---------------- height ----------------
  logic signed [32:0] sum;
  logic [31:0]        mag_q;
  logic               neg_q [3];
  logic [48:0]        amp_prod;
  logic [31:0]        p_q;
  logic [63:0]        prod_q;
  logic [63:0]        rnd;
  logic [19:0]        h_raw, h_sat;

  always_comb begin
    sum      = 33'(sin_q[0]) + (act_line_q[ACT_DLY-1] ? 33'(sin_q[1]) : 33'sd0);
    amp_prod = 49'(mag_q) * 49'(amp_q);
    rnd      = prod_q + (64'd1 << 43);
    h_raw    = rnd[63:44];
    h_sat    = (h_raw > HEIGHT_MAX) ? HEIGHT_MAX : h_raw;
  end

  // Magnitude, amplitude, damping, then round and saturate
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q    <= sum[32] ? 32'(-sum) : sum[31:0];
      neg_q[0] <= sum[32];
      p_q      <= amp_prod[47:16];
      neg_q[1] <= neg_q[0];
      prod_q   <= 64'(p_q) * 64'(e_line_q[E_DLY-1]);
      neg_q[2] <= neg_q[1];
    end
  end

  // ---------------- output register ----------------
  logic [POS_W-1:0]        x_out_q, y_out_q;
  logic signed [HGT_W-1:0] h_out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_out_q <= xp_line_q[POS_DLY-1];
      y_out_q <= yp_line_q[POS_DLY-1];
      h_out_q <= neg_q[2] ? -$signed(HGT_W'(h_sat)) : $signed(HGT_W'(h_sat));
    end
  end

  assign res_o.valid  = vld_q[STG_OUT];
  assign res_o.x_pos  = x_out_q;
  assign res_o.y_pos  = y_out_q;
  assign res_o.height = h_out_q;

endmodule

`default_nettype wire

FILE: hdl/dwh_div_cell.sv
// One step of a pipelined restoring divider: one quotient bit per cell.
// Depends on dwh_pkg for div_t and widths.
`default_nettype none

module dwh_div_cell import dwh_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [REM_W-1:0] divisor_i,
  input  div_t             in_i,
  output div_t             out_o
);

  logic [REM_W:0] trial;
  logic           fits;
  div_t           cell_d, cell_q;

  // Shift the next dividend bit into the remainder and try a subtract
  always_comb begin
    trial       = {in_i.rem, in_i.word[DIV_W-1]};
    fits        = (trial >= {1'b0, divisor_i});
    cell_d.rem  = fits ? REM_W'(trial - {1'b0, divisor_i}) : trial[REM_W-1:0];
    cell_d.word = {in_i.word[DIV_W-2:0], fits};
  end

  // Advance with the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule

`default_nettype wire

FILE: hdl/dwh_horner_cell.sv
// One Horner step t' = 1 - ((op*t) >> 30) / c, three pipeline stages.
// Depends on dwh_pkg for hrn_t and ONE_Q30.
`default_nettype none

module dwh_horner_cell import dwh_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [7:0]  coef_i,
  input  logic [31:0] recip_i,
  input  hrn_t        in_i,
  output hrn_t        out_o
);

  logic [31:0] x1_q, op1_q, aux1_q;
  logic [31:0] x2_q, q2_q, op2_q, aux2_q;
  logic [62:0] prod1;
  logic [63:0] prod2;
  logic [31:0] qc, rem, c2, q_fix;
  hrn_t        cell_d, cell_q;

  // Product, reciprocal estimate, then exact correction of the quotient
  always_comb begin
    prod1 = 63'(in_i.op) * 63'(in_i.t);
    prod2 = 64'(x1_q) * 64'(recip_i);
    qc    = q2_q * 32'(coef_i);
    rem   = x2_q - qc;
    c2    = {23'b0, coef_i, 1'b0};
    if (rem >= c2) begin
      q_fix = q2_q + 32'd2;
    end else if (rem >= 32'(coef_i)) begin
      q_fix = q2_q + 32'd1;
    end else begin
      q_fix = q2_q;
    end
    cell_d.op  = op2_q;
    cell_d.t   = ONE_Q30 - q_fix[30:0];
    cell_d.aux = aux2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= prod1[61:30];
      op1_q  <= in_i.op;
      aux1_q <= in_i.aux;
      x2_q   <= x1_q;
      q2_q   <= prod2[63:32];
      op2_q  <= op1_q;
      aux2_q <= aux1_q;
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule

`default_nettype wire

FILE: hdl/dwh_checker.sv
// Port-level checker for the decaying wave height grid, bound to the top level.
// Depends on dwh_pkg and decaying_wave_height_grid_assert.svh.
`default_nettype none

`include "decaying_wave_height_grid_assert.svh"

module dwh_checker import dwh_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    item_ready_i,
  input logic                    cfg_valid_i,
  input logic                    cfg_ready_i,
  input logic                    res_valid_i,
  input logic                    res_ready_i,
  input logic [POS_W-1:0]        x_pos_i,
  input logic signed [HGT_W-1:0] height_i
);

  // A stalled result holds its valid, x position and height
  `DWH_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(x_pos_i) && $stable(height_i))

  // Register writes are never refused
  `DWH_ASSERT_NOW(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_i)

  // Input is only held off by a waiting result
  `DWH_ASSERT_NOW(a_in_ready, clk_i, rst_ni, !res_valid_i || res_ready_i, item_ready_i)

  // Height saturates at plus or minus two
  `DWH_ASSERT_NOW(a_height_rng, clk_i, rst_ni, res_valid_i, (height_i <= 19'sd131072) && (height_i >= -19'sd131072))

  // Positions stay inside the domain
  `DWH_ASSERT_NOW(a_xpos_rng, clk_i, rst_ni, res_valid_i, x_pos_i <= FOURPI_Q16)

endmodule

bind decaying_wave_height_grid dwh_checker u_dwh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .item_ready_i (item_i.ready),
  .cfg_valid_i  (cfg_i.valid),
  .cfg_ready_i  (cfg_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .x_pos_i      (res_o.x_pos),
  .height_i     (res_o.height)
);

`default_nettype wire

FILE: tb/dwh_checker.sv
// Scoreboard for the decaying wave grid: mirrors the register writes, predicts
// each point's position and damped height, and compares every result in order.
// Depends on dwh_pkg and the channel interfaces in dwh_if.
`default_nettype none

module dwh_scoreboard import dwh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dwh_item_if         item,
  dwh_cfg_if          cfg,
  dwh_res_if          res,
  output int unsigned pending_o,
  output int unsigned errors_o
);

  typedef struct packed {
    logic [POS_W-1:0]        x_pos;
    logic [POS_W-1:0]        y_pos;
    logic signed [HGT_W-1:0] height;
  } point_res_t;

  // Shadow copy of the register file
  logic [16:0] amp_q;
  logic [15:0] len_q;
  logic [15:0] freq_q;
  logic [18:0] pitch_q;
  logic [17:0] decay_q;
  logic [8:0]  nx_q;
  logic [8:0]  ny_q;

  point_res_t expected_q[$];
  int unsigned err_cnt;

  assign pending_o = expected_q.size();
  assign errors_o  = err_cnt;

  function automatic logic [63:0] grid_coord(logic [63:0] idx, logic [8:0] npts);
    logic [63:0] n;
    n = (npts < 2) ? 64'd2 : (npts > MAX_POINTS) ? 64'(MAX_POINTS) : 64'(npts);
    if (idx >= n) idx = n - 1;
    return (idx * 64'(FOURPI_Q16) + n / 2) / n;
  endfunction

  // Sine of a phase in turns, signed Q.30
  function automatic longint turn_sine(logic [31:0] ph);
    logic [63:0] r, a, a2, t, s, k;
    r = 64'(ph[29:0]);
    if (ph[30]) r = 64'(ONE_Q30) - r;
    a  = (r * 64'(HALFPI_Q30)) >> 30;
    a2 = (a * a) >> 30;
    t  = 64'(ONE_Q30);
    for (k = 12; k >= 2; k -= 2)
      t = 64'(ONE_Q30) - ((a2 * t) >> 30) / (k * (k + 1));
    s = (a * t) >> 30;
    if (s > 64'(ONE_Q30)) s = 64'(ONE_Q30);
    return ph[31] ? -longint'(s) : longint'(s);
  endfunction

  // exp(-v) for v in Q.32, result Q.30
  function automatic logic [63:0] damping(logic [63:0] v);
    logic [63:0] n, r30, t, k;
    n   = v / 64'(LN2_Q32);
    r30 = (v - n * 64'(LN2_Q32)) >> 2;
    t   = 64'(ONE_Q30);
    for (k = 9; k >= 1; k--)
      t = 64'(ONE_Q30) - ((r30 * t) >> 30) / k;
    if (n >= 31) return 64'd0;
    return t >> n;
  endfunction

  function automatic point_res_t predict_point(logic [7:0] col, logic [7:0] row,
                                               logic [31:0] tv, logic counter);
    point_res_t  p;
    logic [63:0] xp, yp, len, mag, prod, e, h;
    logic [31:0] spc, tph;
    longint      sum;
    logic        neg;
    xp  = grid_coord(64'(col), nx_q);
    yp  = grid_coord(64'(row), ny_q);
    len = (len_q == 0) ? 64'd1 : 64'(len_q);
    spc = 32'((xp << 32) / len);
    tph = 32'(64'(freq_q) * 64'(pitch_q) * 64'(tv));
    sum = turn_sine(spc - tph);
    if (counter) sum += turn_sine(spc + tph);
    neg  = sum < 0;
    mag  = neg ? 64'(-sum) : 64'(sum);
    prod = (mag * 64'(amp_q)) >> 16;
    e    = damping(64'(decay_q) * yp);
    h    = (prod * e + (64'd1 << 43)) >> 44;
    if (h > 64'(HEIGHT_MAX)) h = 64'(HEIGHT_MAX);
    p.x_pos  = xp[POS_W-1:0];
    p.y_pos  = yp[POS_W-1:0];
    p.height = neg ? -HGT_W'(h) : HGT_W'(h);
    return p;
  endfunction

  // Track register writes, predict accepted points, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    point_res_t want;
    if (!rst_ni) begin
      amp_q   <= 17'd32768;
      len_q   <= 16'd6554;
      freq_q  <= 16'd20000;
      pitch_q <= 19'd65536;
      decay_q <= 18'd13107;
      nx_q    <= 9'd150;
      ny_q    <= 9'd150;
      expected_q.delete();
      err_cnt <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_AMPLITUDE: amp_q   <= cfg.data[16:0];
          REG_LENGTH:    len_q   <= cfg.data[15:0];
          REG_FREQUENCY: freq_q  <= cfg.data[15:0];
          REG_PITCH:     pitch_q <= cfg.data[18:0];
          REG_DECAY:     decay_q <= cfg.data[17:0];
          REG_POINTS_X:  nx_q    <= cfg.data[8:0];
          REG_POINTS_Y:  ny_q    <= cfg.data[8:0];
          default: ;
        endcase
      end
      if (item.valid && item.ready)
        expected_q.push_back(predict_point(item.col_index, item.row_index,
                                           item.time_value, item.action));
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          if (err_cnt < 10) $display("unexpected result x=%0d y=%0d h=%0d",
                                     res.x_pos, res.y_pos, res.height);
          err_cnt <= err_cnt + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.x_pos !== res.x_pos || want.y_pos !== res.y_pos ||
              want.height !== res.height) begin
            if (err_cnt < 10)
              $display("result mismatch: expected x=%0d y=%0d h=%0d, got x=%0d y=%0d h=%0d",
                       want.x_pos, want.y_pos, want.height,
                       res.x_pos, res.y_pos, res.height);
            err_cnt <= err_cnt + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench top for the decaying wave grid: clock, reset, register phases,
// directed and random grid points, random stalls on both sides, verdict.
// Depends on dwh_pkg, dwh_if, dwh_scoreboard and the block itself.
`default_nettype none

module tb import dwh_pkg::*;;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int IDLE_PCT   = 28;
  localparam int STALL_MAX  = 3000;
  localparam int DRAIN_WAIT = 150;

  logic clk_i;
  logic rst_ni;

  dwh_item_if item_if ();
  dwh_cfg_if  cfg_if ();
  dwh_res_if  res_if ();

  int unsigned pending;
  int unsigned errors;
  int unsigned n_items, n_counter, n_writes, n_phases;
  int unsigned quiet_cycles;
  bit          calm;

  decaying_wave_height_grid dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  dwh_scoreboard u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item      (item_if),
    .cfg       (cfg_if),
    .res       (res_if),
    .pending_o (pending),
    .errors_o  (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Receiver: random backpressure
  always @(posedge clk_i) begin
    res_if.ready <= !idle_now();
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Hold one register write until it is taken, then drop valid for a cycle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(negedge clk_i);
    while (!cfg_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    n_writes++;
  endtask

  // Idle at random, then hold one point on the channel until it is taken
  task automatic send_point(logic [7:0] col, logic [7:0] row, logic [31:0] tv, logic act);
    while (idle_now()) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid      <= 1'b1;
    item_if.col_index  <= col;
    item_if.row_index  <= row;
    item_if.time_value <= tv;
    item_if.action     <= act;
    @(negedge clk_i);
    while (!item_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    n_items++;
    if (act) n_counter++;
  endtask

  // Drop valid and wait for every expected result
  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic load_regs(logic [31:0] amp, logic [31:0] len, logic [31:0] freq,
                           logic [31:0] pitch, logic [31:0] dec, logic [31:0] nx,
                           logic [31:0] ny);
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_LENGTH, len);
    write_reg(REG_FREQUENCY, freq);
    write_reg(REG_PITCH, pitch);
    write_reg(REG_DECAY, dec);
    write_reg(REG_POINTS_X, nx);
    write_reg(REG_POINTS_Y, ny);
    n_phases++;
  endtask

  // Random point: mostly inside the grid, sometimes anywhere
  task automatic random_points(int count, int nx, int ny);
    logic [7:0] col, row;
    for (int i = 0; i < count; i++) begin
      calm = (n_items >= 600 && n_items < 850);
      if ($urandom_range(9) == 0) begin
        col = 8'($urandom);
        row = 8'($urandom);
      end else begin
        col = 8'($urandom_range((nx > 256 ? 256 : nx) - 1));
        row = 8'($urandom_range((ny > 256 ? 256 : ny) - 1));
      end
      send_point(col, row, $urandom, 1'($urandom));
    end
    calm = 1'b0;
  endtask

  initial begin
    int nx, ny;
    item_if.valid      = 1'b0;
    item_if.col_index  = '0;
    item_if.row_index  = '0;
    item_if.time_value = '0;
    item_if.action     = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_AMPLITUDE;
    cfg_if.data        = '0;
    res_if.ready       = 1'b0;
    calm = 1'b0;
    n_items = 0; n_counter = 0; n_writes = 0; n_phases = 0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points under the reset settings: corners, zero and full time
    send_point(8'd0, 8'd0, 32'd0, 1'b0);
    send_point(8'd0, 8'd0, 32'd0, 1'b1);
    send_point(8'd149, 8'd149, 32'hFFFF_FFFF, 1'b0);
    send_point(8'd149, 8'd149, 32'hFFFF_FFFF, 1'b1);
    send_point(8'd255, 8'd255, 32'h0001_0000, 1'b1);
    send_point(8'd150, 8'd0, 32'h8000_0000, 1'b0);
    send_point(8'd75, 8'd200, 32'h0000_0001, 1'b1);
    send_point(8'hAA, 8'h55, 32'hAAAA_AAAA, 1'b0);
    send_point(8'h55, 8'hAA, 32'h5555_5555, 1'b1);
    drain();

    // Largest amplitude, shortest wave, fastest time, strongest decay, full grid
    load_regs(65536, 655, 50000, 327680, 131072, 256, 256);
    send_point(8'd255, 8'd255, 32'hFFFF_FFFF, 1'b1);
    send_point(8'd0, 8'd255, 32'h1234_5678, 1'b0);
    send_point(8'd128, 8'd0, 32'd0, 1'b1);
    drain();

    // Smallest settings; zero amplitude keeps the height at zero
    load_regs(0, 32768, 1000, 6554, 0, 2, 2);
    send_point(8'd1, 8'd1, 32'h0000_4000, 1'b1);
    send_point(8'd255, 8'd0, 32'hFFFF_FFFF, 1'b0);
    drain();

    // Out-of-range: zero wavelength, tiny and oversized grids, overlarge gains
    load_regs(131071, 0, 65535, 524287, 0, 0, 511);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_point(8'd0, 8'd255, 32'd0, 1'b1);
    send_point(8'd3, 8'd17, 32'h0000_8000, 1'b1);
    send_point(8'd1, 8'd0, 32'hFFFF_FFFF, 1'b0);
    drain();
    load_regs(65536, 1000, 50000, 327680, 262143, 1, 300);
    send_point(8'd2, 8'd255, 32'h0F0F_0F0F, 1'b1);
    send_point(8'd0, 8'd1, 32'hF0F0_F0F0, 1'b0);
    drain();

    // Random phases, each with its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      nx = (ph == 1) ? 256 : (ph == 2) ? 2 : $urandom_range(256, 2);
      ny = (ph == 1) ? 256 : (ph == 2) ? 3 : $urandom_range(256, 2);
      load_regs($urandom_range(65536), $urandom_range(32768, 655),
                $urandom_range(50000, 1000), $urandom_range(327680, 6554),
                (ph == 3) ? 0 : $urandom_range(131072), nx, ny);
      random_points(258, nx, ny);
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Covered %0d points (%0d counter-propagating) over %0d register settings,",
             n_items, n_counter, n_phases);
    $display("with %0d register writes and random stalls on both channels.", n_writes);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
